### hw/rtl/rbpc_pkg.sv
// ---------------------------------------------------------------------------
// rbpc_pkg: shared types and constants for the rotated box collision block
// Entry layout, number formats, command and word codes, register indexes.
// ---------------------------------------------------------------------------
package rbpc_pkg;

    // table sizing and number formats
    localparam int MAX_OBSTACLES   = 32;
    localparam int COORD_FRAC_BITS = 8;
    localparam int ROT_FRAC_BITS   = 14;

    localparam int IDX_W     = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CNT_W     = $clog2(MAX_OBSTACLES + 1);
    localparam int IN_IDX_W  = 5;
    localparam int SEL_W     = 4;
    localparam int COORD_W   = 20;
    localparam int TRIG_W    = 16;
    localparam int COUNT_W   = 6;
    localparam int MARGIN_W  = 19;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = TRIG_W + DIFF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int ROT_W     = SUM_W - ROT_FRAC_BITS;
    localparam int TPT_W     = ROT_W + 1;
    localparam int CMP_W     = TPT_W + 1;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // register reset values
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(30);
    localparam logic [MARGIN_W-1:0] MARGIN_RESET =
        MARGIN_W'(((22 << COORD_FRAC_BITS) + 5) / 10);

    // register indexes (paddr[2])
    localparam logic REG_COUNT  = 1'b0;
    localparam logic REG_MARGIN = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [SEL_W-1:0] {
        W_CX   = 4'd0,
        W_CZ   = 4'd1,
        W_COS  = 4'd2,
        W_SIN  = 4'd3,
        W_MINX = 4'd4,
        W_MAXX = 4'd5,
        W_MINY = 4'd6,
        W_MAXY = 4'd7,
        W_MINZ = 4'd8,
        W_MAXZ = 4'd9
    } word_sel_t;

    // one obstacle table entry, as stored in the memory
    typedef struct packed {
        coord_t cx;
        coord_t cz;
        trig_t  cs;
        trig_t  sn;
        coord_t minx;
        coord_t maxx;
        coord_t miny;
        coord_t maxy;
        coord_t minz;
        coord_t maxz;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // status of the hit test pipeline toward the controller
    typedef struct packed {
        logic valid;
        logic hit;
        logic busy;
    } hit_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_QUERY,
        ST_DRAIN,
        ST_DONE
    } ctrl_state_t;

endpackage

### hw/rtl/rbpc_ram.sv
// ---------------------------------------------------------------------------
// rbpc_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module rbpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/rbpc_hit.sv
// ---------------------------------------------------------------------------
// rbpc_hit: pipelined point versus oriented box test
// Offset, rotate into the box frame, truncate, then compare, with margin on x and z.
// ---------------------------------------------------------------------------
module rbpc_hit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  rbpc_pkg::entry_t               entry,
    input  rbpc_pkg::coord_t               point_x,
    input  rbpc_pkg::coord_t               point_y,
    input  rbpc_pkg::coord_t               point_z,
    input  logic [rbpc_pkg::MARGIN_W-1:0]  margin,
    output rbpc_pkg::hit_status_t          status
);

    import rbpc_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg;
    entry_t                   e1_reg, e2_reg, e3_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dz1_reg;
    logic signed [DIFF_W-1:0] dx1_next, dz1_next;
    logic signed [PROD_W-1:0] pcx2_reg, psz2_reg, psx2_reg, pcz2_reg;
    logic signed [PROD_W-1:0] pcx2_next, psz2_next, psx2_next, pcz2_next;
    logic signed [SUM_W-1:0]  sumx, sumz;
    logic signed [TPT_W-1:0]  tx3_reg, tz3_reg, tx3_next, tz3_next;
    logic signed [CMP_W-1:0]  tx_hi, tx_lo, tz_hi, tz_lo;
    logic signed [CMP_W-1:0]  minx_e, maxx_e, minz_e, maxz_e;
    logic                     hit_x, hit_y, hit_z;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // offset from the box centre
    assign dx1_next = {point_x[COORD_W-1], point_x} - {entry.cx[COORD_W-1], entry.cx};
    assign dz1_next = {point_z[COORD_W-1], point_z} - {entry.cz[COORD_W-1], entry.cz};

    // rotation products
    assign pcx2_next = e1_reg.cs * dx1_reg;
    assign psz2_next = e1_reg.sn * dz1_reg;
    assign psx2_next = e1_reg.sn * dx1_reg;
    assign pcz2_next = e1_reg.cs * dz1_reg;

    // sum, floor shift and back to world position
    assign sumx = {pcx2_reg[PROD_W-1], pcx2_reg} - {psz2_reg[PROD_W-1], psz2_reg};
    assign sumz = {psx2_reg[PROD_W-1], psx2_reg} + {pcz2_reg[PROD_W-1], pcz2_reg};
    assign tx3_next = {sumx[SUM_W-1], sumx[SUM_W-1:ROT_FRAC_BITS]}
                    + {{(TPT_W-COORD_W){e2_reg.cx[COORD_W-1]}}, e2_reg.cx};
    assign tz3_next = {sumz[SUM_W-1], sumz[SUM_W-1:ROT_FRAC_BITS]}
                    + {{(TPT_W-COORD_W){e2_reg.cz[COORD_W-1]}}, e2_reg.cz};

    // pipeline payload
    always_ff @(posedge clk)
    begin
        e1_reg   <= entry;
        dx1_reg  <= dx1_next;
        dz1_reg  <= dz1_next;
        e2_reg   <= e1_reg;
        pcx2_reg <= pcx2_next;
        psz2_reg <= psz2_next;
        psx2_reg <= psx2_next;
        pcz2_reg <= pcz2_next;
        e3_reg   <= e2_reg;
        tx3_reg  <= tx3_next;
        tz3_reg  <= tz3_next;
    end

    // widened box compares
    assign tx_hi  = {tx3_reg[TPT_W-1], tx3_reg} + {{(CMP_W-MARGIN_W){1'b0}}, margin};
    assign tx_lo  = {tx3_reg[TPT_W-1], tx3_reg} - {{(CMP_W-MARGIN_W){1'b0}}, margin};
    assign tz_hi  = {tz3_reg[TPT_W-1], tz3_reg} + {{(CMP_W-MARGIN_W){1'b0}}, margin};
    assign tz_lo  = {tz3_reg[TPT_W-1], tz3_reg} - {{(CMP_W-MARGIN_W){1'b0}}, margin};
    assign minx_e = {{(CMP_W-COORD_W){e3_reg.minx[COORD_W-1]}}, e3_reg.minx};
    assign maxx_e = {{(CMP_W-COORD_W){e3_reg.maxx[COORD_W-1]}}, e3_reg.maxx};
    assign minz_e = {{(CMP_W-COORD_W){e3_reg.minz[COORD_W-1]}}, e3_reg.minz};
    assign maxz_e = {{(CMP_W-COORD_W){e3_reg.maxz[COORD_W-1]}}, e3_reg.maxz};

    assign hit_x = (minx_e < tx_hi) && (maxx_e > tx_lo);
    assign hit_z = (minz_e < tz_hi) && (maxz_e > tz_lo);
    assign hit_y = (e3_reg.miny < point_y) && (e3_reg.maxy > point_y);

    assign status.valid = v3_reg;
    assign status.hit   = hit_x && hit_y && hit_z;
    assign status.busy  = v1_reg || v2_reg || v3_reg;

endmodule

### hw/rtl/rotated_box_point_collision.sv
// ---------------------------------------------------------------------------
// rotated_box_point_collision: point test against a table of rotated boxes
// Loads write one word of a table entry; queries answer one collision flag.
// ---------------------------------------------------------------------------
// A load beat reads the entry, then writes back the merged word.
// A query beat reads n = min(obstacle_count, 32) entries before its result;
// the single table read port visits one entry per cycle, then the
// hit pipeline drains. The result waits in an output register while loads go on.
// Reset clears the controller and sets obstacle_count to 30 and box_margin
// to 2.2; table contents are undefined until loaded.
module rotated_box_point_collision (
    input  logic                           clk,
    input  logic                           rst_n,
    // item channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           command,
    input  logic [rbpc_pkg::IN_IDX_W-1:0]  obstacle_index,
    input  logic [rbpc_pkg::SEL_W-1:0]     word_select,
    input  logic signed [rbpc_pkg::COORD_W-1:0] word_value,
    input  logic signed [rbpc_pkg::COORD_W-1:0] point_x,
    input  logic signed [rbpc_pkg::COORD_W-1:0] point_y,
    input  logic signed [rbpc_pkg::COORD_W-1:0] point_z,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           collision,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rbpc_pkg::APB_AW-1:0]    paddr,
    input  logic [rbpc_pkg::APB_DW-1:0]    pwdata,
    output logic [rbpc_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    import rbpc_pkg::*;

    ctrl_state_t           state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [MARGIN_W-1:0]   margin_reg;
    logic [CNT_W-1:0]      issue_reg, lim_reg, lim_now;
    logic                  acc_reg;
    coord_t                px_reg, py_reg, pz_reg;
    logic [IDX_W-1:0]      ld_idx_reg;
    logic                  ld_ok_reg;
    word_sel_t             ld_sel_reg;
    coord_t                ld_val_reg;
    logic                  rd_valid_reg;
    logic                  out_valid_reg, collision_reg;

    logic [IDX_W+IN_IDX_W-1:0] idx_wide;
    logic [IDX_W-1:0]      ram_raddr;
    logic                  ram_re, ram_we, sel_known;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                merged;
    logic                  in_beat, load_beat, query_beat, issue_last, out_load;
    logic                  cfg_wr;
    hit_status_t           hit_st;

    assign in_beat    = in_valid && in_ready;
    assign load_beat  = in_beat && (cmd_t'(command) == CMD_LOAD);
    assign query_beat = in_beat && (cmd_t'(command) == CMD_QUERY);
    assign idx_wide   = {{IDX_W{1'b0}}, obstacle_index};
    assign lim_now    = (int'(count_reg) > MAX_OBSTACLES) ? CNT_W'(MAX_OBSTACLES)
                                                          : CNT_W'(count_reg);
    assign issue_last = ((issue_reg + CNT_W'(1)) == lim_reg);

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= COUNT_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_COUNT:  count_reg  <= pwdata[COUNT_W-1:0];
                REG_MARGIN: margin_reg <= pwdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_COUNT:  prdata = {{(APB_DW-COUNT_W){1'b0}}, count_reg};
            REG_MARGIN: prdata = {{(APB_DW-MARGIN_W){1'b0}}, margin_reg};
            default:    prdata = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_beat)
                    state_next = ST_LOAD;
                else if (query_beat)
                    state_next = (lim_now == '0) ? ST_DRAIN : ST_QUERY;
            end
            ST_LOAD:  state_next = ST_IDLE;
            ST_QUERY:
            begin
                if (issue_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !hit_st.busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = issue_reg[IDX_W-1:0];
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ram_re    = load_beat;
                ram_raddr = idx_wide[IDX_W-1:0];
            end
            ST_QUERY: ram_re = 1'b1;
            ST_DONE:  out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    // merge the loaded word into the entry read back
    always_comb
    begin
        merged    = entry_t'(ram_rdata);
        sel_known = 1'b1;
        case (ld_sel_reg)
            W_CX:    merged.cx   = ld_val_reg;
            W_CZ:    merged.cz   = ld_val_reg;
            W_COS:   merged.cs   = ld_val_reg[TRIG_W-1:0];
            W_SIN:   merged.sn   = ld_val_reg[TRIG_W-1:0];
            W_MINX:  merged.minx = ld_val_reg;
            W_MAXX:  merged.maxx = ld_val_reg;
            W_MINY:  merged.miny = ld_val_reg;
            W_MAXY:  merged.maxy = ld_val_reg;
            W_MINZ:  merged.minz = ld_val_reg;
            W_MAXZ:  merged.maxz = ld_val_reg;
            default: sel_known   = 1'b0;
        endcase
    end

    assign ram_we = (state_reg == ST_LOAD) && ld_ok_reg && sel_known;

    // controller registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= '0;
            acc_reg       <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_QUERY);
            if (query_beat)
                issue_reg <= '0;
            else if (state_reg == ST_QUERY)
                issue_reg <= issue_reg + CNT_W'(1);
            if (query_beat)
                acc_reg <= 1'b0;
            else if (hit_st.valid && hit_st.hit)
                acc_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // beat payload capture
    always_ff @(posedge clk)
    begin
        if (query_beat)
        begin
            px_reg  <= point_x;
            py_reg  <= point_y;
            pz_reg  <= point_z;
            lim_reg <= lim_now;
        end
        if (load_beat)
        begin
            ld_idx_reg <= idx_wide[IDX_W-1:0];
            ld_ok_reg  <= (int'(obstacle_index) < MAX_OBSTACLES);
            ld_sel_reg <= word_sel_t'(word_select);
            ld_val_reg <= word_value;
        end
        if (out_load)
            collision_reg <= acc_reg;
    end

    assign out_valid = out_valid_reg;
    assign collision = collision_reg;

    // obstacle table
    rbpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_OBSTACLES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ld_idx_reg),
        .wdata (merged),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // hit test pipeline
    rbpc_hit u_hit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .entry    (entry_t'(ram_rdata)),
        .point_x  (px_reg),
        .point_y  (py_reg),
        .point_z  (pz_reg),
        .margin   (margin_reg),
        .status   (hit_st)
    );

endmodule

### hw/rtl/rbpc_checker.sv
// ---------------------------------------------------------------------------
// rbpc_checker: port level assertions for the collision block
// Result hold, busy windows after load and query beats, result origin.
// ---------------------------------------------------------------------------
module rbpc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic command,
    input logic out_valid,
    input logic out_ready,
    input logic collision
);

    import rbpc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(collision))
        else $error("result beat changed while stalled");

    // a query beat keeps the block busy the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_QUERY) |=> !in_ready)
        else $error("item taken during a query");

    // a load beat makes the block busy for its write-back alone, then ready again
    a_load_len: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_LOAD) |=> !in_ready ##1 in_ready)
        else $error("load beat timing wrong");

    // a result only appears at the end of a busy query
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result beat without a query");

endmodule

bind rotated_box_point_collision rbpc_checker u_checker (.*);

### tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: rotated box point collision check
// Drives load and query beats with random idling on both channels, predicts
// the collision flag for each query, and compares every result beat in order.
// Register writes happen between phases, once the block has gone idle.
// ---------------------------------------------------------------------------
module testbench;

    import rbpc_pkg::*;

    localparam int SETTLE_CYCLES   = MAX_OBSTACLES + 16;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int PHASES          = 8;
    localparam int COORD_SPAN      = (1 << COORD_W) - 1;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 command;
    logic [IN_IDX_W-1:0]  obstacle_index;
    logic [SEL_W-1:0]     word_select;
    coord_t               word_value;
    coord_t               point_x;
    coord_t               point_y;
    coord_t               point_z;
    logic                 out_valid;
    logic                 out_ready;
    logic                 collision;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // obstacle table shadow and expected collision flags
    class collision_scoreboard;
        entry_t               obstacles [MAX_OBSTACLES];
        logic [COUNT_W-1:0]   count;
        logic [MARGIN_W-1:0]  margin;
        bit                   expected_flags [$];
        int                   fails;

        function new();
            count  = COUNT_RESET;
            margin = MARGIN_RESET;
            fails  = 0;
        endfunction

        function void set_register(logic reg_idx, logic [APB_DW-1:0] value);
            if (reg_idx == REG_COUNT)
                count = value[COUNT_W-1:0];
            else
                margin = value[MARGIN_W-1:0];
        endfunction

        // point rotated into the box frame, then tested against bounds widened on x and z
        function bit box_hit(entry_t e, longint px, longint py, longint pz);
            longint m;
            longint c_x;
            longint c_z;
            longint c_s;
            longint s_n;
            longint dx;
            longint dz;
            longint tx;
            longint tz;
            longint lo_x;
            longint hi_x;
            longint lo_y;
            longint hi_y;
            longint lo_z;
            longint hi_z;
            m    = margin;
            c_x  = e.cx;
            c_z  = e.cz;
            c_s  = e.cs;
            s_n  = e.sn;
            lo_x = e.minx;
            hi_x = e.maxx;
            lo_y = e.miny;
            hi_y = e.maxy;
            lo_z = e.minz;
            hi_z = e.maxz;
            dx   = px - c_x;
            dz   = pz - c_z;
            tx   = ((c_s * dx - s_n * dz) >>> ROT_FRAC_BITS) + c_x;
            tz   = ((s_n * dx + c_s * dz) >>> ROT_FRAC_BITS) + c_z;
            return (lo_x < tx + m) && (hi_x > tx - m) &&
                   (lo_y < py) && (hi_y > py) &&
                   (lo_z < tz + m) && (hi_z > tz - m);
        endfunction

        function bit point_collides(coord_t px, coord_t py, coord_t pz);
            int n;
            bit any;
            n   = (count > MAX_OBSTACLES) ? MAX_OBSTACLES : count;
            any = 0;
            for (int i = 0; i < n; i++)
                if (box_hit(obstacles[i], px, py, pz))
                    any = 1;
            return any;
        endfunction

        // accepted input beat: loads update the shadow, queries queue a flag
        function void note_beat(logic cmd, logic [IN_IDX_W-1:0] idx,
                                logic [SEL_W-1:0] sel, coord_t value,
                                coord_t px, coord_t py, coord_t pz);
            if (cmd == CMD_QUERY) begin
                expected_flags.push_back(point_collides(px, py, pz));
            end
            else if (idx < MAX_OBSTACLES) begin
                case (sel)
                    W_CX:    obstacles[idx].cx   = value;
                    W_CZ:    obstacles[idx].cz   = value;
                    W_COS:   obstacles[idx].cs   = value[TRIG_W-1:0];
                    W_SIN:   obstacles[idx].sn   = value[TRIG_W-1:0];
                    W_MINX:  obstacles[idx].minx = value;
                    W_MAXX:  obstacles[idx].maxx = value;
                    W_MINY:  obstacles[idx].miny = value;
                    W_MAXY:  obstacles[idx].maxy = value;
                    W_MINZ:  obstacles[idx].minz = value;
                    W_MAXZ:  obstacles[idx].maxz = value;
                    default: ;
                endcase
            end
        endfunction

        function void check_flag(logic got);
            bit want;
            if (expected_flags.size() == 0) begin
                $error("collision beat with no query pending: actual %0b", got);
                fails++;
            end
            else begin
                want = expected_flags.pop_front();
                if (got !== want) begin
                    $error("collision mismatch: expected %0b, actual %0b", want, got);
                    fails++;
                end
            end
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    collision_scoreboard sb;
    int in_calm;
    int out_calm;

    rotated_box_point_collision dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .obstacle_index (obstacle_index),
        .word_select    (word_select),
        .word_value     (word_value),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .collision      (collision),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap before the next beat, with occasional stretches of back-to-back beats
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 16);
    endfunction

    function automatic int spread(int reach);
        return int'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    // one input beat; fields that the command ignores carry random values
    task automatic send_beat(cmd_t cmd, int idx, int sel, int value,
                             int px, int py, int pz);
        int gap;
        gap = draw_gap(in_calm);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        if (cmd == CMD_QUERY) begin
            obstacle_index <= IN_IDX_W'($urandom);
            word_select    <= SEL_W'($urandom);
            word_value     <= COORD_W'($urandom);
            point_x        <= COORD_W'(px);
            point_y        <= COORD_W'(py);
            point_z        <= COORD_W'(pz);
        end
        else begin
            obstacle_index <= IN_IDX_W'(idx);
            word_select    <= SEL_W'(sel);
            word_value     <= COORD_W'(value);
            point_x        <= COORD_W'($urandom);
            point_y        <= COORD_W'($urandom);
            point_z        <= COORD_W'($urandom);
        end
        do @(posedge clk); while (!in_ready);
        sb.note_beat(command, obstacle_index, word_select, word_value,
                     point_x, point_y, point_z);
    endtask

    // rewrite a whole entry as a plausible box around a random centre
    task automatic load_entry(int idx);
        int  vals [10];
        int  c_x;
        int  c_z;
        int  y_mid;
        int  wx;
        int  wy;
        int  wz;
        int  deg;
        real ang;
        c_x   = spread(1 << 17);
        c_z   = spread(1 << 17);
        y_mid = spread(1 << 15);
        wx    = $urandom_range(16, 4096);
        wy    = $urandom_range(16, 4096);
        wz    = $urandom_range(16, 4096);
        if ($urandom_range(0, 3) == 0)
            deg = 90 * $urandom_range(0, 3);
        else
            deg = $urandom_range(0, 359);
        ang = deg * 3.14159265358979 / 180.0;
        vals[W_CX]   = c_x;
        vals[W_CZ]   = c_z;
        // upper word bits are junk for cosine and sine
        vals[W_COS]  = int'($cos(ang) * 16384.0) + ($urandom_range(0, 15) << TRIG_W);
        vals[W_SIN]  = int'($sin(ang) * 16384.0) + ($urandom_range(0, 15) << TRIG_W);
        vals[W_MINX] = c_x - $urandom_range(0, wx);
        vals[W_MAXX] = c_x + $urandom_range(0, wx);
        vals[W_MINY] = y_mid - $urandom_range(0, wy);
        vals[W_MAXY] = y_mid + $urandom_range(0, wy);
        vals[W_MINZ] = c_z - $urandom_range(0, wz);
        vals[W_MAXZ] = c_z + $urandom_range(0, wz);
        for (int k = W_CX; k <= W_MAXZ; k++)
            send_beat(CMD_LOAD, idx, k, vals[k], 0, 0, 0);
    endtask

    // drop valid, then wait until every result is in and the block has settled
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, then read back
    task automatic write_register(logic reg_idx, logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(reg_idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value) begin
            $error("prdata mismatch: expected %0d, actual %0d", value, prdata);
            sb.fails++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random stalls, check each beat
    initial
    begin
        out_ready = 1'b0;
        out_calm  = 0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = draw_gap(out_calm);
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_flag(collision);
        end
    end

    // stimulus
    initial
    begin
        int     phase_count [PHASES];
        int     phase_margin [PHASES];
        int     items;
        int     choice;
        int     n_eff;
        int     reach;
        int     sel;
        entry_t e;

        phase_count  = '{32, 33, 63, 1, 16, 0, 30, 32};
        phase_margin = '{563, 0, 524287, 563, 1500, 200, 40, 0};
        phase_margin[PHASES-1] = $urandom_range(0, (1 << MARGIN_W) - 1);

        sb             = new();
        in_calm        = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_LOAD;
        obstacle_index = '0;
        word_select    = W_CX;
        word_value     = '0;
        point_x        = '0;
        point_y        = '0;
        point_z        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero count always answers no collision, even with no table loaded
        write_register(REG_COUNT, 0);
        write_register(REG_MARGIN, 0);
        send_beat(CMD_QUERY, 0, 0, 0, 0, 0, 0);
        send_beat(CMD_QUERY, 0, 0, 0, -524288, 524287, -524288);

        // entry 0: unit box at origin; cosine and sine words carry junk high bits
        send_beat(CMD_LOAD, 0, W_CX,   0,       0, 0, 0);
        send_beat(CMD_LOAD, 0, W_CZ,   0,       0, 0, 0);
        send_beat(CMD_LOAD, 0, W_COS,  -49152,  0, 0, 0);
        send_beat(CMD_LOAD, 0, W_SIN,  327680,  0, 0, 0);
        send_beat(CMD_LOAD, 0, W_MINX, -256,    0, 0, 0);
        send_beat(CMD_LOAD, 0, W_MAXX, 256,     0, 0, 0);
        send_beat(CMD_LOAD, 0, W_MINY, -256,    0, 0, 0);
        send_beat(CMD_LOAD, 0, W_MAXY, 256,     0, 0, 0);
        send_beat(CMD_LOAD, 0, W_MINZ, -256,    0, 0, 0);
        send_beat(CMD_LOAD, 0, W_MAXZ, 256,     0, 0, 0);
        // unused word select must leave the entry alone
        send_beat(CMD_LOAD, 0, W_MAXZ + 6, -1, 0, 0, 0);

        wait_quiet();
        write_register(REG_COUNT, 1);
        // inside, y on the open bound, x on the edge without margin, near a corner
        send_beat(CMD_QUERY, 0, 0, 0, 0, 0, 0);
        send_beat(CMD_QUERY, 0, 0, 0, 0, 256, 0);
        send_beat(CMD_QUERY, 0, 0, 0, 256, 0, 0);
        send_beat(CMD_QUERY, 0, 0, 0, 255, -255, -255);

        wait_quiet();
        write_register(REG_MARGIN, (1 << MARGIN_W) - 1);
        // widest margin reaches the far ends of the coordinate range
        send_beat(CMD_QUERY, 0, 0, 0, 524287, 0, -524288);

        // 45 degree yaw with negative sine: products round toward minus infinity
        send_beat(CMD_LOAD, 0, W_COS, 11585,  0, 0, 0);
        send_beat(CMD_LOAD, 0, W_SIN, -11585, 0, 0, 0);
        wait_quiet();
        write_register(REG_MARGIN, 0);
        send_beat(CMD_QUERY, 0, 0, 0, 357, 3, -5);
        send_beat(CMD_QUERY, 0, 0, 0, -301, 0, 61);

        // fill the whole table before any larger count is used
        for (int i = 0; i < MAX_OBSTACLES; i++)
            load_entry(i);

        for (int p = 0; p < PHASES; p++) begin
            wait_quiet();
            write_register(REG_COUNT, phase_count[p]);
            write_register(REG_MARGIN, phase_margin[p]);
            items = 0;
            while (items < ITEMS_PER_PHASE) begin
                choice = $urandom_range(0, 99);
                if (choice < 12) begin
                    load_entry($urandom_range(0, MAX_OBSTACLES - 1));
                    items += 10;
                end
                else if (choice < 20) begin
                    // stray word with a full-range value, sometimes an unused select
                    sel = $urandom_range(0, (1 << SEL_W) - 1);
                    send_beat(CMD_LOAD, $urandom_range(0, MAX_OBSTACLES - 1), sel,
                              $urandom_range(0, COORD_SPAN), 0, 0, 0);
                    if (sel <= W_MAXZ)
                        items++;
                end
                else begin
                    n_eff = (sb.count > MAX_OBSTACLES) ? MAX_OBSTACLES : sb.count;
                    if (n_eff == 0)
                        n_eff = MAX_OBSTACLES;
                    if ($urandom_range(0, 99) < 65) begin
                        // point close to one of the boxes in use
                        e = sb.obstacles[$urandom_range(0, n_eff - 1)];
                        case ($urandom_range(0, 2))
                            0:       reach = 256;
                            1:       reach = 2048;
                            default: reach = 8192;
                        endcase
                        send_beat(CMD_QUERY, 0, 0, 0,
                                  int'(e.cx) + spread(reach),
                                  (int'(e.miny) + int'(e.maxy)) / 2 + spread(reach),
                                  int'(e.cz) + spread(reach));
                    end
                    else begin
                        send_beat(CMD_QUERY, 0, 0, 0,
                                  $urandom_range(0, COORD_SPAN),
                                  $urandom_range(0, COORD_SPAN),
                                  $urandom_range(0, COORD_SPAN));
                    end
                    items++;
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait_quiet();
        if (sb.fails == 0)
            $display("rotated_box_point_collision verification clean");
        else
            $display("rotated_box_point_collision verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("rotated_box_point_collision verification failed");
        $finish;
    end

endmodule
